@@ hw/rtl/mfat_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor feedback angle tracker package
// Shared constants and the frame record that travels from front to back.
// ----------------------------------------------------------------------------
package mfat_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ID = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_FRAMES = 1'd1;
	localparam logic [10:0] BASE_ID_RESET = 11'h201;
	localparam logic [7:0] CAL_FRAMES_RESET = 8'd50;

	localparam logic signed [16:0] STEP_LIMIT = 17'sd4096;
	localparam int TURN_SHIFT = 13;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [16:0] DIV5_RECIP = 17'd52429;
	localparam int DIV5_SHIFT = 18;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor;
		logic [15:0] angle;
		logic signed [15:0] meas;
		logic signed [13:0] given;
		logic [7:0] hall;
	} frame_t;

endpackage

@@ hw/rtl/motor_feedback_angle_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Motor feedback angle tracker core
// A result is formed from an accepted frame that passes, in order, through the
// front register, the queue and the output register. Throughput is one frame
// per cycle while the output is not stalled, set by the per-motor state update
// in the back end.
// Reset clears all motor state and restores the identifier and calibration
// registers to their defaults; frames are taken right after reset.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mfat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfat_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [10:0] frame_id,
	input  logic [15:0] angle_word,
	input  logic signed [15:0] current_word,
	input  logic signed [15:0] given_word,
	input  logic [7:0] hall_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] motor_index,
	output logic [15:0] angle_out,
	output logic signed [15:0] measured_current,
	output logic signed [13:0] cmd_current,
	output logic [7:0] hall_out,
	output logic signed [31:0] turn_count,
	output logic signed [31:0] multiturn_angle,
	output logic calibrating
);
	import mfat_pkg::*;

	logic [10:0] base_id_q;
	logic [7:0] cal_frames_q;
	logic push;
	frame_t push_item;
	logic queue_full;
	logic pop;
	logic queue_empty;
	frame_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= BASE_ID_RESET;
			cal_frames_q <= CAL_FRAMES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_ID: begin
					base_id_q <= cfg_data[10:0];
				end
				REG_CAL_FRAMES: begin
					cal_frames_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	mfat_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_id     (frame_id),
		.angle_word   (angle_word),
		.current_word (current_word),
		.given_word   (given_word),
		.hall_byte    (hall_byte),
		.base_id      (base_id_q),
		.push         (push),
		.push_item    (push_item),
		.queue_full   (queue_full)
	);

	mfat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.pop_item  (pop_item)
	);

	mfat_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.empty            (queue_empty),
		.pop_item         (pop_item),
		.pop              (pop),
		.cal_frames       (cal_frames_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.motor_index      (motor_index),
		.angle_out        (angle_out),
		.measured_current (measured_current),
		.cmd_current      (cmd_current),
		.hall_out         (hall_out),
		.turn_count       (turn_count),
		.multiturn_angle  (multiturn_angle),
		.calibrating      (calibrating)
	);

endmodule

@@ hw/rtl/mfat_front.sv @@
// ----------------------------------------------------------------------------
// Motor feedback angle tracker front end
// Takes frames, drops those outside the identifier window and scales the
// commanded current.
// ----------------------------------------------------------------------------
module mfat_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [10:0] frame_id,
	input  logic [15:0] angle_word,
	input  logic signed [15:0] current_word,
	input  logic signed [15:0] given_word,
	input  logic [7:0] hall_byte,
	input  logic [10:0] base_id,
	output logic push,
	output mfat_pkg::frame_t push_item,
	input  logic queue_full
);
	import mfat_pkg::*;

	logic valid_s1;
	frame_t item_s1;
	logic [11:0] diff;
	logic in_window;
	logic load;
	logic [16:0] abs_given;
	logic [33:0] prod;
	logic [12:0] mag;
	logic signed [13:0] quot;

	assign diff = {1'b0, frame_id} - {1'b0, base_id};
	assign in_window = !diff[11] && (diff < 12'(MOTOR_COUNT));

	// Negated quotient by five through a reciprocal, exact for magnitudes below 2^18.
	assign abs_given = given_word[15] ? (17'd0 - {given_word[15], given_word})
		: {1'b0, given_word};
	assign prod = {17'd0, abs_given} * {17'd0, DIV5_RECIP};
	assign mag = prod[DIV5_SHIFT+12:DIV5_SHIFT];
	assign quot = given_word[15] ? $signed({1'b0, mag}) : $signed(14'd0 - {1'b0, mag});

	assign in_stall = valid_s1 & queue_full;
	assign load = in_valid & !in_stall & in_window;
	assign push = valid_s1 & !queue_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & queue_full);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.motor <= diff[MOTOR_W-1:0];
			item_s1.angle <= angle_word;
			item_s1.meas <= current_word;
			item_s1.given <= quot;
			item_s1.hall <= hall_byte;
		end
	end

endmodule

@@ hw/rtl/mfat_queue.sv @@
// ----------------------------------------------------------------------------
// Motor feedback angle tracker queue
// Two-entry first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module mfat_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mfat_pkg::frame_t push_item,
	output logic full,
	input  logic pop,
	output logic empty,
	output mfat_pkg::frame_t pop_item
);
	import mfat_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push & !full;
	assign do_pop = pop & !empty;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/mfat_back.sv @@
// ----------------------------------------------------------------------------
// Motor feedback angle tracker back end
// Keeps per-motor angle, turn, offset and frame count state and forms the
// result in an output register.
// ----------------------------------------------------------------------------
module mfat_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  mfat_pkg::frame_t pop_item,
	output logic pop,
	input  logic [7:0] cal_frames,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] motor_index,
	output logic [15:0] angle_out,
	output logic signed [15:0] measured_current,
	output logic signed [13:0] cmd_current,
	output logic [7:0] hall_out,
	output logic signed [31:0] turn_count,
	output logic signed [31:0] multiturn_angle,
	output logic calibrating
);
	import mfat_pkg::*;

	logic [15:0] last_q [MOTOR_COUNT];
	logic [31:0] turn_q [MOTOR_COUNT];
	logic [15:0] offset_q [MOTOR_COUNT];
	logic [7:0] count_q [MOTOR_COUNT];

	logic out_valid_q;
	logic [1:0] motor_q;
	logic [15:0] angle_q;
	logic signed [15:0] meas_q;
	logic signed [13:0] given_q;
	logic [7:0] hall_q;
	logic [31:0] turn_out_q;
	logic [31:0] total_q;
	logic calib_q;

	logic [MOTOR_W-1:0] m;
	logic calib;
	logic signed [16:0] step;
	logic [31:0] turn_new;
	logic [15:0] offset_new;
	logic [31:0] total_new;

	assign pop = !empty & (!out_valid_q | !out_stall);
	assign m = pop_item.motor;

	assign calib = (count_q[m] <= cal_frames);
	assign step = $signed({1'b0, pop_item.angle}) - $signed({1'b0, last_q[m]});

	always_comb begin
		turn_new = turn_q[m];
		if (!calib) begin
			if (step > STEP_LIMIT) begin
				turn_new = turn_q[m] - 32'd1;
			end else if (step < -STEP_LIMIT) begin
				turn_new = turn_q[m] + 32'd1;
			end
		end
	end

	assign offset_new = calib ? pop_item.angle : offset_q[m];
	assign total_new = (turn_new << TURN_SHIFT) + {16'd0, pop_item.angle} - {16'd0, offset_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_q[i] <= '0;
				turn_q[i] <= '0;
				offset_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				last_q[m] <= pop_item.angle;
				turn_q[m] <= turn_new;
				offset_q[m] <= offset_new;
				if (count_q[m] != COUNT_MAX) begin
					count_q[m] <= count_q[m] + 8'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			motor_q <= 2'(pop_item.motor);
			angle_q <= pop_item.angle;
			meas_q <= pop_item.meas;
			given_q <= pop_item.given;
			hall_q <= pop_item.hall;
			turn_out_q <= turn_new;
			total_q <= total_new;
			calib_q <= calib;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_index = motor_q;
	assign angle_out = angle_q;
	assign measured_current = meas_q;
	assign cmd_current = given_q;
	assign hall_out = hall_q;
	assign turn_count = $signed(turn_out_q);
	assign multiturn_angle = $signed(total_q);
	assign calibrating = calib_q;

endmodule
